/* rtl/agsc_pkg.sv */
package agsc_pkg;

  // item field widths
  localparam int SAMPLE_W = 24;
  localparam int PROD_W   = 48;
  localparam int VAL_W    = 49;
  localparam int DEN_W    = 48;

  // quotient bits of the soft clip divide: the floored bend stays below FS/4
  localparam int QB = SAMPLE_W - 3;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // full scale related constants, before the fraction shift
  localparam int FS16_3Q   = 24576;
  localparam int FS24_3Q   = 6291456;
  localparam int FS16_HALF = 16384;
  localparam int FS24_HALF = 4194304;

  // exponent of the soft clip numerator, without the fraction bits
  localparam int N16_EXP = 26;
  localparam int N24_EXP = 42;

  // saturation bounds
  localparam logic signed [VAL_W-1:0] MAX16 = 49'sd32767;
  localparam logic signed [VAL_W-1:0] MIN16 = -49'sd32768;
  localparam logic signed [VAL_W-1:0] MAX24 = 49'sd8388607;
  localparam logic signed [VAL_W-1:0] MIN24 = -49'sd8388608;

  // item classes
  localparam logic [1:0] CLS_SAT      = 2'd0;
  localparam logic [1:0] CLS_SOFT_POS = 2'd1;
  localparam logic [1:0] CLS_SOFT_NEG = 2'd2;

  // register indexes
  localparam logic [1:0] REG_GAIN = 2'd0;
  localparam logic [1:0] REG_SOFT = 2'd1;
  localparam logic [1:0] REG_WIDE = 2'd2;

  typedef struct packed {
    logic [SAMPLE_W-1:0] gain;
    logic                soft_clip;
    logic                wide;
  } agsc_cfg_t;

  typedef struct packed {
    logic [1:0]              cls;
    logic signed [VAL_W-1:0] val;
    logic [DEN_W-1:0]        den;
  } agsc_item_t;

endpackage

/* rtl/agsc_front.sv */
module agsc_front #(
  parameter int FRAC_BITS = 20
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic signed [agsc_pkg::SAMPLE_W-1:0]      sample_in,
  input  agsc_pkg::agsc_cfg_t                       cfg,
  input  logic                                      q_full,
  output logic                                      q_push,
  output logic                                      item_valid,
  output agsc_pkg::agsc_item_t                      item
);
  import agsc_pkg::*;

  localparam int UW = (FRAC_BITS + 1 > SAMPLE_W) ? FRAC_BITS + 1 : SAMPLE_W;
  localparam int CW = (FRAC_BITS + 25 > VAL_W) ? FRAC_BITS + 25 : VAL_W;

  localparam logic [UW-1:0] UNITY = {{(UW-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic signed [CW-1:0] THR16 = CW'(FS16_3Q) << FRAC_BITS;
  localparam logic signed [CW-1:0] THR24 = CW'(FS24_3Q) << FRAC_BITS;
  localparam logic signed [CW-1:0] HFS16 = CW'(FS16_HALF) << FRAC_BITS;
  localparam logic signed [CW-1:0] HFS24 = CW'(FS24_HALF) << FRAC_BITS;
  localparam logic signed [VAL_W-1:0] HALF = {{(VAL_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

  logic                       fen;
  logic                       va, vb;
  logic signed [SAMPLE_W-1:0] sa, sb;
  logic signed [PROD_W-1:0]   pb;
  logic signed [VAL_W-1:0]    prod;

  logic [UW-1:0]           gain_ext;
  logic                    unity, above;
  logic signed [CW-1:0]    p_cw, thr, hfs, den_cw;
  logic signed [VAL_W-1:0] rnd_sum, rnd;
  logic                    soft_pos, soft_neg;
  agsc_item_t              item_next;

  // whole front moves unless the last stage waits on a full queue
  assign fen      = !(item_valid && q_full);
  assign in_stall = !fen;
  assign q_push   = item_valid && !q_full;

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      va         <= 1'b0;
      vb         <= 1'b0;
      item_valid <= 1'b0;
    end else if (fen) begin
      va         <= in_valid;
      vb         <= va;
      item_valid <= vb;
    end
  end

  // sample width select and gain multiply
  assign prod = sa * $signed({1'b0, cfg.gain});

  always_ff @(posedge clk) begin
    if (fen) begin
      sa   <= cfg.wide ? sample_in : {{8{sample_in[15]}}, sample_in[15:0]};
      sb   <= sa;
      pb   <= prod[PROD_W-1:0];
      item <= item_next;
    end
  end

  // classify the product
  assign gain_ext = UW'(cfg.gain);
  assign unity    = (gain_ext == UNITY);
  assign above    = (gain_ext > UNITY);
  assign p_cw     = {{(CW-PROD_W){pb[PROD_W-1]}}, pb};
  assign thr      = cfg.wide ? THR24 : THR16;
  assign hfs      = cfg.wide ? HFS24 : HFS16;
  assign soft_pos = cfg.soft_clip && above && (p_cw > thr);
  assign soft_neg = cfg.soft_clip && above && (p_cw < -thr);
  assign den_cw   = soft_pos ? (p_cw - hfs) : (-p_cw - hfs);

  // round half up
  assign rnd_sum = {pb[PROD_W-1], pb} + HALF;
  assign rnd     = rnd_sum >>> FRAC_BITS;

  always_comb begin
    item_next.den = den_cw[DEN_W-1:0];
    item_next.val = unity ? {{(VAL_W-SAMPLE_W){sb[SAMPLE_W-1]}}, sb} : rnd;
    priority if (soft_pos) begin
      item_next.cls = CLS_SOFT_POS;
    end else if (soft_neg) begin
      item_next.cls = CLS_SOFT_NEG;
    end else begin
      item_next.cls = CLS_SAT;
    end
  end

endmodule

/* rtl/agsc_fifo.sv */
module agsc_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  agsc_pkg::agsc_item_t item_in,
  input  logic                 pop,
  output agsc_pkg::agsc_item_t head,
  output logic                 full,
  output logic                 empty
);
  import agsc_pkg::*;

  agsc_item_t     mem [0:QDEPTH-1];
  logic [QAW-1:0] wp, rp;
  logic [QAW:0]   count;

  assign full  = (count == (QAW+1)'(QDEPTH));
  assign empty = (count == '0);
  assign head  = mem[rp];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= item_in;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/agsc_back.sv */
module agsc_back #(
  parameter int FRAC_BITS = 20
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  agsc_pkg::agsc_item_t                 head,
  input  logic                                 q_empty,
  output logic                                 q_pop,
  input  logic                                 wide,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [agsc_pkg::SAMPLE_W-1:0] sample_out
);
  import agsc_pkg::*;

  localparam int DW = (FRAC_BITS + N24_EXP + 1 > DEN_W + QB - 1) ?
                      FRAC_BITS + N24_EXP + 1 : DEN_W + QB - 1;
  localparam logic [DW-1:0] NUM16 = {{(DW-1){1'b0}}, 1'b1} << (FRAC_BITS + N16_EXP);
  localparam logic [DW-1:0] NUM24 = {{(DW-1){1'b0}}, 1'b1} << (FRAC_BITS + N24_EXP);

  logic                     adv;
  logic                     v_s   [0:QB];
  logic [DW-1:0]            rem_s [0:QB];
  logic [QB-1:0]            q_s   [0:QB];
  logic [DEN_W-1:0]         den_s [0:QB];
  logic [1:0]               cls_s [0:QB];
  logic [SAMPLE_W-1:0]      res_s [0:QB];

  logic [DW-1:0]            dsh   [0:QB-1];
  logic                     ge    [0:QB-1];

  logic signed [VAL_W-1:0]  hi, lo;
  logic [SAMPLE_W-1:0]      sat;
  logic [QB:0]              qc;
  logic signed [SAMPLE_W:0] fs25, pos, neg;
  logic [SAMPLE_W-1:0]      out_next;

  // back pipeline moves as a whole unless the output is held
  assign adv   = !out_valid || !out_stall;
  assign q_pop = adv && !q_empty;

  // saturation of rounded and pass-through values
  assign hi = wide ? MAX24 : MAX16;
  assign lo = wide ? MIN24 : MIN16;
  always_comb begin
    priority if (head.val > hi) begin
      sat = hi[SAMPLE_W-1:0];
    end else if (head.val < lo) begin
      sat = lo[SAMPLE_W-1:0];
    end else begin
      sat = head.val[SAMPLE_W-1:0];
    end
  end

  // one quotient bit per stage, restoring
  always_comb begin
    for (int i = 0; i < QB; i++) begin
      dsh[i] = DW'(den_s[i]) << (QB - 1 - i);
      ge[i]  = (rem_s[i] >= dsh[i]);
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= QB; i++) begin
        v_s[i] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (adv) begin
      v_s[0] <= !q_empty;
      for (int i = 0; i < QB; i++) begin
        v_s[i+1] <= v_s[i];
      end
      out_valid <= v_s[QB];
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      rem_s[0] <= wide ? NUM24 : NUM16;
      q_s[0]   <= '0;
      den_s[0] <= head.den;
      cls_s[0] <= head.cls;
      res_s[0] <= sat;
      for (int i = 0; i < QB; i++) begin
        rem_s[i+1] <= ge[i] ? (rem_s[i] - dsh[i]) : rem_s[i];
        q_s[i+1]   <= {q_s[i][QB-2:0], ge[i]};
        den_s[i+1] <= den_s[i];
        cls_s[i+1] <= cls_s[i];
        res_s[i+1] <= res_s[i];
      end
      sample_out <= out_next;
    end
  end

  // ceiling of the quotient, then bend toward full scale
  assign qc   = {1'b0, q_s[QB]} + (QB+1)'(|rem_s[QB]);
  assign fs25 = wide ? 25'sh0800000 : 25'sh0008000;
  assign pos  = fs25 - $signed({{(SAMPLE_W-QB){1'b0}}, qc});
  assign neg  = -pos;

  always_comb begin
    unique case (cls_s[QB])
      CLS_SOFT_POS: out_next = pos[SAMPLE_W-1:0];
      CLS_SOFT_NEG: out_next = neg[SAMPLE_W-1:0];
      default:      out_next = res_s[QB];
    endcase
  end

endmodule

/* rtl/audio_gain_soft_clipper.sv */
// channel   | handshake             | payload
// ----------+-----------------------+------------------------------
// input     | in_valid / in_stall   | sample_in, 24 bit signed
// output    | out_valid / out_stall | sample_out, 24 bit signed
// config    | cfg_valid / cfg_ready | cfg_index 2 bit, cfg_data 24 bit
//
// one sample per cycle sustained while out_stall is low; an input passes through
// 27 register stages: 3 front, queue, load, 21 divider bits, output register.
// rst is synchronous and clears all valids, the queue and the registers to
// unity gain, hard clipping, 16-bit full scale; cfg_ready is always high.
// output stall holds the back pipeline; the front keeps taking samples until
// the 4-entry queue fills, then raises in_stall.
module audio_gain_soft_clipper #(
  parameter int FRAC_BITS = 20
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [agsc_pkg::SAMPLE_W-1:0] sample_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [agsc_pkg::SAMPLE_W-1:0] sample_out,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [1:0]                           cfg_index,
  input  logic [agsc_pkg::SAMPLE_W-1:0]        cfg_data
);
  import agsc_pkg::*;

  localparam int UW = (FRAC_BITS + 1 > SAMPLE_W) ? FRAC_BITS + 1 : SAMPLE_W;
  localparam logic [UW-1:0] UNITY = {{(UW-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic [SAMPLE_W-1:0] GAIN_RESET = UNITY[SAMPLE_W-1:0];

  agsc_cfg_t  cfg;
  logic       q_push, q_pop, q_full, q_empty, item_valid;
  agsc_item_t item, head;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain      <= GAIN_RESET;
      cfg.soft_clip <= 1'b0;
      cfg.wide      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GAIN: cfg.gain      <= cfg_data;
        REG_SOFT: cfg.soft_clip <= cfg_data[0];
        REG_WIDE: cfg.wide      <= cfg_data[0];
        default:  cfg.gain      <= cfg.gain;
      endcase
    end
  end

  agsc_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample_in  (sample_in),
    .cfg        (cfg),
    .q_full     (q_full),
    .q_push     (q_push),
    .item_valid (item_valid),
    .item       (item)
  );

  agsc_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .item_in (item),
    .pop     (q_pop),
    .head    (head),
    .full    (q_full),
    .empty   (q_empty)
  );

  agsc_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .wide       (cfg.wide),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out)
  );

  // queue never overfills or underflows
  a_push_not_full: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("queue written while full");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("queue read while empty");

  // front only blocks input while it holds an item for the queue
  a_stall_cause: assert property (@(posedge clk) disable iff (rst) in_stall |-> item_valid)
    else $error("input stalled with no pending item");

endmodule

/* dv/audio_gain_soft_clipper_test.sv */
`timescale 1ns / 100ps

module audio_gain_soft_clipper_test;
  import agsc_pkg::*;

  localparam int FRAC_BITS = 20;
  localparam logic [23:0] UNITY = 24'd1 << FRAC_BITS;
  localparam logic [23:0] GAIN_MAX = 24'd10485760;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 100;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SAMPLE_W-1:0] sample_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [SAMPLE_W-1:0] cfg_data = '0;

  // shadow of the configuration registers
  logic [23:0] cur_gain = UNITY;
  logic cur_soft = 1'b0;
  logic cur_wide = 1'b0;

  logic [23:0] pending_samples[$];
  logic [23:0] expected_samples[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic want_hold = 1'b0;
  logic hold_done = 1'b0;
  int hold_left = 0;
  int idle_cycles = 0;
  int n_in = 0;
  int n_out = 0;
  int n_cfg = 0;
  int n_settings = 0;
  int n_fail = 0;

  audio_gain_soft_clipper #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample_in(sample_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sample_out(sample_out),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // expected gained sample under the current register settings
  function automatic logic [23:0] gain_clip_sample(logic [23:0] raw_in);
    int wbits;
    int n;
    longint fs, s, p, half, thr, hfs, r;
    longint unsigned numer, den, quo;
    wbits = cur_wide ? 24 : 16;
    fs = longint'(1) << (wbits - 1);
    if (cur_wide) s = longint'($signed(raw_in));
    else s = longint'($signed(raw_in[15:0]));
    if (cur_gain == UNITY) begin
      r = s;
    end else begin
      p = s * longint'(cur_gain);
      half = longint'(1) << (FRAC_BITS - 1);
      thr = (3 * (fs >>> 2)) << FRAC_BITS;
      hfs = (fs >>> 1) << FRAC_BITS;
      n = 2 * wbits - 6 + FRAC_BITS;
      numer = 64'd1 << n;
      if (cur_gain < UNITY) begin
        r = (p + half) >>> FRAC_BITS;
      end else if (cur_soft && p > thr) begin
        // bend toward full scale, quotient rounded up
        den = p - hfs;
        quo = numer / den + ((numer % den) != 0 ? 64'd1 : 64'd0);
        r = fs - longint'(quo);
      end else if (cur_soft && p < -thr) begin
        den = -p - hfs;
        quo = numer / den + ((numer % den) != 0 ? 64'd1 : 64'd0);
        r = -(fs - longint'(quo));
      end else begin
        r = (p + half) >>> FRAC_BITS;
        if (r > fs - 1) r = fs - 1;
        else if (r < -fs) r = -fs;
      end
    end
    return r[23:0];
  endfunction

  // random sample, weighted toward the clipping region of the gain
  function automatic logic [23:0] pick_sample(logic [23:0] g, logic w);
    longint fs, mag, v;
    fs = w ? 64'sd8388608 : 64'sd32768;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 24'($urandom);
      5, 6: mag = longint'($urandom_range(0, 255));
      7, 8: begin
        if (g == 0) mag = longint'($urandom_range(0, 32'(fs - 1)));
        else mag = (longint'($urandom_range(32'(fs / 2), 32'(fs))) << FRAC_BITS)
                   / longint'(g);
        if (mag > fs) mag = fs;
      end
      default: begin
        case ($urandom_range(0, 3))
          0: mag = 0;
          1: mag = 1;
          2: mag = fs - 1;
          default: mag = fs;
        endcase
      end
    endcase
    v = $urandom_range(0, 1) ? -mag : mag;
    if (v > fs - 1) v = fs - 1;
    // junk in the unused upper bits of a narrow sample
    if (!w) v = (v & 64'hFFFF) | (longint'($urandom_range(0, 255)) << 16);
    return v[23:0];
  endfunction

  function automatic logic [23:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return UNITY;
      1: return 24'($urandom_range(0, 32'(UNITY - 24'd1)));
      2: return 24'($urandom_range(32'(UNITY) + 32'd1, 32'(GAIN_MAX)));
      3: return GAIN_MAX;
      4: return 24'd0;
      5: return 24'hFFFFFF;
      6: return 24'($urandom);
      default: return 24'($urandom_range(32'(UNITY) + 32'd1, 32'd4 * 32'(UNITY)));
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    n_fail++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(logic [23:0] g, logic [23:0] soft_data, logic [23:0] wide_data);
    write_reg(REG_GAIN, g);
    write_reg(REG_SOFT, soft_data);
    write_reg(REG_WIDE, wide_data);
    n_settings++;
  endtask

  // wait until every queued sample has gone through and come back
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_samples.size() != 0);
  endtask

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_samples.push_back(gain_clip_sample(sample_in));
        n_in++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          sample_in <= pending_samples.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output stall, with one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (want_hold && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    logic [23:0] want;
    if (!rst && out_valid && !out_stall) begin
      n_out++;
      if (expected_samples.size() == 0) begin
        report_mismatch($sformatf("unexpected output %h", sample_out));
      end else begin
        want = expected_samples.pop_front();
        if (sample_out !== want)
          report_mismatch($sformatf("sample_out %h, expected %h", sample_out, want));
      end
    end
  end

  // track register writes
  always @(posedge clk) begin
    if (rst) begin
      cur_gain <= UNITY;
      cur_soft <= 1'b0;
      cur_wide <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      n_cfg++;
      case (cfg_index)
        REG_GAIN: cur_gain <= cfg_data;
        REG_SOFT: cur_soft <= cfg_data[0];
        REG_WIDE: cur_wide <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    logic [23:0] g;
    logic w;
    int k, i;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 16;
    recv_stall_pct = 71;

    // reset settings: unity, hard clip, 16-bit; upper bits dropped
    @(negedge clk);
    pending_samples.push_back(24'h000000);
    pending_samples.push_back(24'h007FFF);
    pending_samples.push_back(24'h008000);
    pending_samples.push_back(24'h7FFFFF);
    pending_samples.push_back(24'h800000);
    pending_samples.push_back(24'h123456);
    wait_drained();

    // zero gain, wide
    apply_setting(24'd0, 24'd0, 24'd1);
    @(negedge clk);
    pending_samples.push_back(24'h7FFFFF);
    pending_samples.push_back(24'h800000);
    pending_samples.push_back(24'h000001);
    wait_drained();

    // half gain, rounding of halves both signs
    apply_setting(24'd524288, 24'd0, 24'hFFFFFF);
    @(negedge clk);
    pending_samples.push_back(24'h000001);
    pending_samples.push_back(24'hFFFFFF);
    pending_samples.push_back(24'h000003);
    pending_samples.push_back(24'hFFFFFD);
    pending_samples.push_back(24'h7FFFFF);
    wait_drained();

    // top gain, soft clip, narrow: just below and above the knee
    apply_setting(GAIN_MAX, 24'hFFFFFF, 24'hFFFFFE);
    @(negedge clk);
    pending_samples.push_back(24'h007FFF);
    pending_samples.push_back(24'hFF8000);
    pending_samples.push_back(24'd2457);
    pending_samples.push_back(24'd2458);
    pending_samples.push_back(-24'sd2458);
    pending_samples.push_back(24'h000000);
    wait_drained();

    // largest register value, hard clip, wide; unused index has no effect
    apply_setting(24'hFFFFFF, 24'hFFFFFE, 24'd1);
    write_reg(REG_UNUSED, 24'h000000);
    @(negedge clk);
    pending_samples.push_back(24'h7FFFFF);
    pending_samples.push_back(24'h800000);
    pending_samples.push_back(24'h000001);
    pending_samples.push_back(24'hFFFFFF);
    wait_drained();

    // random settings and samples
    for (k = 0; k < PHASES; k++) begin
      if (k < PHASES / 3) begin
        send_idle_pct = 16;
        recv_stall_pct = 71;
      end else if (k < 2 * PHASES / 3) begin
        send_idle_pct = 71;
        recv_stall_pct = 16;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      g = pick_gain();
      w = 1'($urandom_range(0, 1));
      apply_setting(g, (24'($urandom) & 24'hFFFFFE) | 24'($urandom_range(0, 1)),
                    (24'($urandom) & 24'hFFFFFE) | {23'd0, w});
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, 24'($urandom));
      @(negedge clk);
      // fill the pipe against a held output
      if (k == 2 * PHASES / 3) want_hold = 1'b1;
      for (i = 0; i < PHASE_ITEMS; i++) pending_samples.push_back(pick_sample(g, w));
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_samples.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_samples.size()));
    $display("run covered %0d samples, %0d results, %0d register writes over %0d settings",
             n_in, n_out, n_cfg, n_settings);
    $display("gains from zero to register max, hard and soft clip, 16 and 24 bit scale");
    if (n_fail == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
